[rtl/delimited_text_dimension_scan_unit_assert.svh]
// Assertion macros for the delimited text dimension scan unit.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef DELIMITED_TEXT_DIMENSION_SCAN_UNIT_ASSERT_SVH
`define DELIMITED_TEXT_DIMENSION_SCAN_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DTDS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DTDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dtds_pkg.sv]
// Package for the delimited text dimension scan unit.
// Byte codes, status codes and the result beat type; no dependencies.
`default_nettype none

package dtds_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RowOutW = 16;
  localparam int unsigned ColOutW = 10;
  localparam int unsigned StatW   = 2;

  localparam logic [ByteW-1:0] CH_LF      = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR      = 8'h0D;
  localparam logic [ByteW-1:0] CH_TAB     = 8'h09;
  localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;
  localparam logic [ByteW-1:0] CH_COMMA   = 8'h2C;
  localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
  localparam logic [ByteW-1:0] CH_HASH    = 8'h23;

  typedef enum logic [StatW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_INCONS = 2'd1,
    STATUS_EMPTY  = 2'd2
  } status_e;

  typedef struct packed {
    logic [RowOutW-1:0] row_count;
    logic [ColOutW-1:0] col_count;
    status_e            status;
    logic [RowOutW-1:0] bad_row;
  } result_t;

endpackage

`default_nettype wire

[rtl/dtds_in_if.sv]
// Input byte channel of the delimited text dimension scan unit.
// Valid/ready handshake; widths from dtds_pkg.
`default_nettype none

interface dtds_in_if;
  logic                      valid;
  logic                      ready;
  logic [dtds_pkg::ByteW-1:0] byte_value;
  logic                      is_last;

  modport source (output valid, output byte_value, output is_last, input ready);
  modport sink   (input valid, input byte_value, input is_last, output ready);
endinterface

`default_nettype wire

[rtl/dtds_out_if.sv]
// Result channel of the delimited text dimension scan unit.
// Valid/ready handshake; widths from dtds_pkg.
`default_nettype none

interface dtds_out_if;
  logic                         valid;
  logic                         ready;
  logic [dtds_pkg::RowOutW-1:0] row_count;
  logic [dtds_pkg::ColOutW-1:0] col_count;
  logic [dtds_pkg::StatW-1:0]   status;
  logic [dtds_pkg::RowOutW-1:0] bad_row;

  modport source (output valid, output row_count, output col_count, output status,
                  output bad_row, input ready);
  modport sink   (input valid, input row_count, input col_count, input status,
                  input bad_row, output ready);
endinterface

`default_nettype wire

[rtl/delimited_text_dimension_scan_unit.sv]
// Channel  Dir  Payload                                   Beat
// in_i     in   byte_value[7:0], is_last                  one text byte
// out_o    out  row_count[15:0], col_count[9:0],          one per file,
//               status[1:0], bad_row[15:0]                after the last byte
//
// One byte is taken every cycle unless in_i stalls; scan state updates in the cycle of the beat.
// The result of a last byte is valid on out_o from the next cycle, unless an
// older result still waits there; then it follows once that one is taken.
// A two-entry result buffer (output register plus skid) parts the two sides;
// in_i stalls only while both entries are full.
// Reset clears all scan state and empties the result buffer.
//
// Delimited text dimension scan: counts data lines and columns of a text stream.
// Depends on dtds_pkg, dtds_in_if, dtds_out_if and the assertion header.
`default_nettype none

`include "delimited_text_dimension_scan_unit_assert.svh"

module delimited_text_dimension_scan_unit #(
  parameter int unsigned ROW_BITS = 16,
  parameter int unsigned COL_BITS = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dtds_in_if.sink   in_i,
  dtds_out_if.source out_o
);

  import dtds_pkg::*;

  localparam logic [ROW_BITS-1:0] RowMax = {ROW_BITS{1'b1}};
  localparam logic [COL_BITS-1:0] ColMax = {COL_BITS{1'b1}};

  typedef enum logic [1:0] {
    CLS_EOL,
    CLS_CMT,
    CLS_SEP,
    CLS_TXT
  } byte_cls_e;

  // scan state
  logic                in_field_q, in_field_d;
  logic                in_comment_q, in_comment_d;
  logic [COL_BITS-1:0] line_fields_q, line_fields_d;
  logic [COL_BITS-1:0] expected_cols_q, expected_cols_d;
  logic [ROW_BITS-1:0] rows_seen_q, rows_seen_d;
  logic                failed_q, failed_d;
  logic [ROW_BITS-1:0] fail_row_q, fail_row_d;

  // result buffer
  logic    out_valid_q, skid_valid_q;
  result_t out_data_q, skid_data_q;
  result_t result;

  logic      in_fire, push, pop;
  byte_cls_e cls;

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign push       = in_fire && in_i.is_last;
  assign pop        = out_valid_q && out_o.ready;

  always_comb begin
    unique case (in_i.byte_value) inside
      CH_LF, CH_CR:              cls = CLS_EOL;
      CH_PERCENT, CH_HASH:       cls = CLS_CMT;
      CH_COMMA, CH_SPACE, CH_TAB: cls = CLS_SEP;
      default:                   cls = CLS_TXT;
    endcase
  end

  always_comb begin
    logic                fld;
    logic                cmt;
    logic [COL_BITS-1:0] lf;
    logic                close_now;
    logic [COL_BITS-1:0] exp_c;
    logic [ROW_BITS-1:0] rows_c;
    logic                fail_c;
    logic [ROW_BITS-1:0] frow_c;
    logic [ROW_BITS-1:0] rows_inc;

    fld = in_field_q;
    cmt = in_comment_q;
    lf  = line_fields_q;

    if (cls != CLS_EOL && !in_comment_q) begin
      case (cls)
        CLS_CMT: begin
          cmt = 1'b1;
          fld = 1'b0;
        end
        CLS_SEP: fld = 1'b0;
        default: begin
          if (!in_field_q) begin
            fld = 1'b1;
            if (line_fields_q != ColMax) lf = line_fields_q + 1'b1;
          end
        end
      endcase
    end

    close_now = (cls == CLS_EOL) || in_i.is_last;
    exp_c     = expected_cols_q;
    rows_c    = rows_seen_q;
    fail_c    = failed_q;
    frow_c    = fail_row_q;
    rows_inc  = (rows_seen_q == RowMax) ? RowMax : rows_seen_q + 1'b1;

    // close the line: first data line sets the width, later ones must match
    if (close_now && !failed_q && lf != '0) begin
      if (expected_cols_q == '0 || expected_cols_q == lf) begin
        exp_c  = lf;
        rows_c = rows_inc;
      end else begin
        fail_c = 1'b1;
        frow_c = rows_inc;
      end
    end

    result.row_count = RowOutW'(rows_c);
    result.col_count = ColOutW'(exp_c);
    if (fail_c)                          result.status = STATUS_INCONS;
    else if (rows_c == '0 || exp_c == '0) result.status = STATUS_EMPTY;
    else                                 result.status = STATUS_OK;
    result.bad_row = fail_c ? RowOutW'(frow_c) : '0;

    in_field_d      = close_now ? 1'b0 : fld;
    in_comment_d    = close_now ? 1'b0 : cmt;
    line_fields_d   = close_now ? '0 : lf;
    expected_cols_d = exp_c;
    rows_seen_d     = rows_c;
    failed_d        = fail_c;
    fail_row_d      = frow_c;

    // start the next file from reset values
    if (in_i.is_last) begin
      expected_cols_d = '0;
      rows_seen_d     = '0;
      failed_d        = 1'b0;
      fail_row_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_field_q      <= 1'b0;
      in_comment_q    <= 1'b0;
      line_fields_q   <= '0;
      expected_cols_q <= '0;
      rows_seen_q     <= '0;
      failed_q        <= 1'b0;
      fail_row_q      <= '0;
    end else if (in_fire) begin
      in_field_q      <= in_field_d;
      in_comment_q    <= in_comment_d;
      line_fields_q   <= line_fields_d;
      expected_cols_q <= expected_cols_d;
      rows_seen_q     <= rows_seen_d;
      failed_q        <= failed_d;
      fail_row_q      <= fail_row_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      if (out_valid_q) skid_valid_q <= 1'b1;
      else             out_valid_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) out_data_q <= skid_data_q;
      else if (push)    out_data_q <= result;
    end else if (push) begin
      if (out_valid_q) skid_data_q <= result;
      else             out_data_q  <= result;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.row_count = out_data_q.row_count;
  assign out_o.col_count = out_data_q.col_count;
  assign out_o.status    = out_data_q.status;
  assign out_o.bad_row   = out_data_q.bad_row;

  `DTDS_ASSERT(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `DTDS_ASSERT_NEXT(a_last_gives_beat, push, out_valid_q, "last byte left no result beat")
  `DTDS_ASSERT(a_fail_row_set, failed_q, fail_row_q != '0, "mismatch without a line index")
  `DTDS_ASSERT(a_rows_need_width, expected_cols_q == '0, rows_seen_q == '0 && !failed_q,
               "rows counted before the column count was set")

endmodule

`default_nettype wire

[test/tb_delimited_text_dimension_scan_unit.sv]
`timescale 1ns / 100ps
// Testbench for delimited_text_dimension_scan_unit: streams text files byte by byte
// and checks each per-file row, column, status and bad-row result against a predictor.
// Depends on dtds_pkg, dtds_in_if and dtds_out_if.
module tb_delimited_text_dimension_scan_unit;
  import dtds_pkg::*;

  localparam int unsigned ROW_BITS     = 16;
  localparam int unsigned COL_BITS     = 10;
  localparam int unsigned STALL_LIMIT  = 400;
  localparam int unsigned RANDOM_BYTES = 1120;

  typedef struct {
    logic [ByteW-1:0] value;
    logic             last;
    bit               burst;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dtds_in_if  in_bus();
  dtds_out_if out_bus();

  delimited_text_dimension_scan_unit #(
    .ROW_BITS(ROW_BITS),
    .COL_BITS(COL_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Scan state of the predictor
  logic                in_token     = 1'b0;
  logic                in_remark    = 1'b0;
  logic                col_mismatch = 1'b0;
  logic [COL_BITS-1:0] line_cols    = '0;
  logic [COL_BITS-1:0] file_cols    = '0;
  logic [ROW_BITS-1:0] rows_ok      = '0;
  logic [ROW_BITS-1:0] mismatch_row = '0;

  result_t     dims_due[$];
  result_t     want_dims;
  text_beat_t  text_beats[$];
  text_beat_t  next_beat;
  int unsigned errors = 0;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned hold_off;
  int unsigned stall_cycles;
  bit          quiet_spell = 1'b0;

  function automatic void close_text_line();
    if (!col_mismatch && line_cols != '0) begin
      if (file_cols == '0 || file_cols == line_cols) begin
        file_cols = line_cols;
        if (rows_ok != '1) rows_ok++;
      end else begin
        col_mismatch = 1'b1;
        mismatch_row = (rows_ok == '1) ? rows_ok : rows_ok + 1'b1;
      end
    end
    line_cols = '0;
    in_token  = 1'b0;
    in_remark = 1'b0;
  endfunction

  function automatic void track_byte(input logic [ByteW-1:0] b, input logic last);
    result_t dims;
    if (b == CH_LF || b == CH_CR) begin
      close_text_line();
    end else if (in_remark) begin
      // drop the rest of the line
    end else if (b == CH_PERCENT || b == CH_HASH) begin
      in_remark = 1'b1;
      in_token  = 1'b0;
    end else if (b == CH_COMMA || b == CH_SPACE || b == CH_TAB) begin
      in_token = 1'b0;
    end else if (!in_token) begin
      in_token = 1'b1;
      if (line_cols != '1) line_cols++;
    end
    if (last) begin
      close_text_line();
      dims.row_count = RowOutW'(rows_ok);
      dims.col_count = ColOutW'(file_cols);
      if (col_mismatch) dims.status = STATUS_INCONS;
      else if (rows_ok == '0 || file_cols == '0) dims.status = STATUS_EMPTY;
      else dims.status = STATUS_OK;
      dims.bad_row = col_mismatch ? RowOutW'(mismatch_row) : '0;
      dims_due.insert(dims_due.size(), dims);
      // start the next file from reset values
      file_cols    = '0;
      rows_ok      = '0;
      col_mismatch = 1'b0;
      mismatch_row = '0;
    end
  endfunction

  function automatic int unsigned draw_idle();
    if ($urandom_range(0, 63) == 0) quiet_spell = !quiet_spell;
    return quiet_spell ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("dims mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void add_byte(input logic [ByteW-1:0] b, input logic last,
                                   input bit burst);
    text_beat_t beat;
    beat.value = b;
    beat.last  = last;
    beat.burst = burst;
    text_beats.insert(text_beats.size(), beat);
  endfunction

  function automatic void add_text(input string s, input bit burst);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0, burst);
  endfunction

  function automatic logic [ByteW-1:0] field_byte();
    logic [ByteW-1:0] b;
    do begin
      b = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(8'h30, 8'h39));
    end while (b inside {CH_LF, CH_CR, CH_TAB, CH_SPACE, CH_COMMA, CH_PERCENT, CH_HASH});
    return b;
  endfunction

  function automatic logic [ByteW-1:0] sep_byte();
    case ($urandom_range(0, 2))
      0:       return CH_COMMA;
      1:       return CH_SPACE;
      default: return CH_TAB;
    endcase
  endfunction

  function automatic void add_seps(input int unsigned n);
    repeat (n) add_byte(sep_byte(), 1'b0, 1'b0);
  endfunction

  function automatic void add_comment();
    logic [ByteW-1:0] b;
    add_byte($urandom_range(0, 1) ? CH_PERCENT : CH_HASH, 1'b0, 1'b0);
    repeat ($urandom_range(0, 4)) begin
      do b = 8'($urandom); while (b == CH_LF || b == CH_CR);
      add_byte(b, 1'b0, 1'b0);
    end
  endfunction

  function automatic void add_line_end();
    case ($urandom_range(0, 3))
      0: add_byte(CH_LF, 1'b0, 1'b0);
      1: add_byte(CH_CR, 1'b0, 1'b0);
      2: begin
        add_byte(CH_CR, 1'b0, 1'b0);
        add_byte(CH_LF, 1'b0, 1'b0);
      end
      default: begin
        add_byte(CH_LF, 1'b0, 1'b0);
        add_byte(CH_LF, 1'b0, 1'b0);
      end
    endcase
  endfunction

  function automatic void add_random_file();
    int unsigned      cols;
    int unsigned      lines;
    int unsigned      n;
    logic [ByteW-1:0] last_byte;
    cols  = $urandom_range(1, 6);
    lines = $urandom_range(0, 7);
    if ($urandom_range(0, 7) == 0) begin
      // raw noise of any byte value
      repeat ($urandom_range(0, 20)) add_byte(8'($urandom), 1'b0, 1'b0);
    end else begin
      for (int i = 0; i < lines; i++) begin
        case ($urandom_range(0, 15))
          0: begin
            // blank line
          end
          1: add_seps($urandom_range(1, 4));
          2: add_comment();
          3: repeat ($urandom_range(1, 6)) add_byte(8'($urandom), 1'b0, 1'b0);
          default: begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cols + 1) : cols;
            if ($urandom_range(0, 3) == 0) add_seps($urandom_range(1, 3));
            for (int f = 0; f < n; f++) begin
              if (f != 0) add_seps($urandom_range(1, 3));
              repeat ($urandom_range(1, 4)) add_byte(field_byte(), 1'b0, 1'b0);
            end
            if ($urandom_range(0, 3) == 0) add_seps($urandom_range(1, 3));
            if ($urandom_range(0, 5) == 0) add_comment();
          end
        endcase
        add_line_end();
      end
    end
    case ($urandom_range(0, 4))
      0:       last_byte = CH_LF;
      1:       last_byte = CH_CR;
      2:       last_byte = sep_byte();
      3:       last_byte = CH_HASH;
      default: last_byte = field_byte();
    endcase
    add_byte(last_byte, 1'b1, 1'b0);
  endfunction

  // Driver: one beat per pop, then the drawn idle gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      send_wait    <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) track_byte(in_bus.byte_value, in_bus.is_last);
      if (!in_bus.valid || in_bus.ready) begin
        if (send_wait != 0) begin
          in_bus.valid <= 1'b0;
          send_wait    <= send_wait - 1;
        end else if (text_beats.size() != 0) begin
          next_beat          = text_beats.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.byte_value <= next_beat.value;
          in_bus.is_last    <= next_beat.last;
          send_wait         <= next_beat.burst ? 0 : draw_idle();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat, then stall ready for the drawn gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      recv_wait     <= 1;
    end else if (out_bus.valid && out_bus.ready) begin
      if (dims_due.size() == 0) begin
        report_mismatch("unexpected result, row_count", out_bus.row_count, 0);
      end else begin
        want_dims = dims_due.pop_front();
        if (out_bus.row_count !== want_dims.row_count)
          report_mismatch("row_count", out_bus.row_count, want_dims.row_count);
        if (out_bus.col_count !== want_dims.col_count)
          report_mismatch("col_count", out_bus.col_count, want_dims.col_count);
        if (out_bus.status !== want_dims.status)
          report_mismatch("status", out_bus.status, want_dims.status);
        if (out_bus.bad_row !== want_dims.bad_row)
          report_mismatch("bad_row", out_bus.bad_row, want_dims.bad_row);
      end
      hold_off = draw_idle();
      if (hold_off != 0) begin
        out_bus.ready <= 1'b0;
        recv_wait     <= hold_off;
      end
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      if (recv_wait == 1) out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned random_start;
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.byte_value = '0;
    in_bus.is_last    = 1'b0;
    out_bus.ready     = 1'b0;

    // Empty file: a lone line end marked last
    add_byte(CH_LF, 1'b1, 1'b0);
    // Separators only, CRLF, comment line, then high and NUL bytes with a comment: a short line
    // that sets the mismatch; lines after it are scanned but not counted
    add_text(", \t\n", 1'b0);
    add_text("ab c\r\n", 1'b0);
    add_text("%z\n", 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_text("#q\n", 1'b0);
    add_text("d ", 1'b0);
    add_byte(8'h65, 1'b1, 1'b0);
    // One field and no line end
    add_byte(8'h7A, 1'b1, 1'b0);

    random_start = text_beats.size();
    while (text_beats.size() - random_start < RANDOM_BYTES) add_random_file();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (text_beats.size() != 0 || in_bus.valid || dims_due.size() != 0);
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/dtds_pkg.sv
rtl/dtds_in_if.sv
rtl/dtds_out_if.sv
rtl/delimited_text_dimension_scan_unit.sv
test/tb_delimited_text_dimension_scan_unit.sv
